FILE: design/hrf_pkg.sv
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types, codes and constants for the HTTP request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 4096;
    localparam int unsigned METHOD_MAX_DEF   = 7;
    localparam int unsigned PATH_MAX_DEF     = 63;

    localparam int unsigned CNT_W   = 13;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned NAME_LEN = 14;

    localparam logic [CNT_W-1:0] CFG_MAX_RESET = 13'd4096;
    localparam logic [LEN_W-1:0] LEN_SAT       = 16'hFFFF;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_UC_C  = 8'h43;
    localparam logic [7:0] CH_LC_C  = 8'h63;

    localparam logic [0:NAME_LEN-1][7:0] NAME_UPPER = "Content-Length";
    localparam logic [0:NAME_LEN-1][7:0] NAME_LOWER = "content-length";

    typedef enum logic [2:0] {
        ST_COLLECT = 3'd0,
        ST_OK      = 3'd1,
        ST_BAD     = 3'd2,
        ST_BIG     = 3'd3,
        ST_IGNORE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PT_METHOD = 3'd0,
        PT_PATH   = 3'd1,
        PT_REST   = 3'd2,
        PT_BODY   = 3'd3,
        PT_BEYOND = 3'd4
    } t_part;

    typedef enum logic [1:0] {
        LP_METHOD,
        LP_PATH,
        LP_REST
    } t_line_phase;

    typedef enum logic [2:0] {
        VP_NAME,
        VP_COLON,
        VP_SIGN,
        VP_DIGITS,
        VP_DONE
    } t_val_phase;

    typedef enum logic [1:0] {
        FIN_OPEN,
        FIN_DONE,
        FIN_BIG
    } t_fin;

    typedef struct packed {
        logic       conn_start;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [2:0]       part;
        logic [LEN_W-1:0] length_value;
        logic [CNT_W-1:0] body_start;
        logic [CNT_W-1:0] byte_count;
        logic             headers_seen;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic step;
    } t_line_ctl;

    typedef struct packed {
        t_part part;
        logic  bad;
        logic  in_method;
    } t_line_stat;

    typedef struct packed {
        logic clear;
        logic step;
        logic hdr_end;
    } t_val_ctl;

    typedef struct packed {
        logic [LEN_W-1:0] acc;
        logic             neg;
    } t_val_stat;

    function automatic logic [7:0] hrf_name_char(input logic [3:0] pos, input logic lower);
        logic [7:0] ch;
        ch = lower ? NAME_LOWER[pos] : NAME_UPPER[pos];
        return ch;
    endfunction

    function automatic logic hrf_is_space(input logic [7:0] b);
        return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic hrf_is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

FILE: design/hrf_line.sv
// ----------------------------------------------------------------------------
// hrf_line
// Request line tracker: method length check, path length, part tag.
// ----------------------------------------------------------------------------
module hrf_line #(
    parameter int unsigned METHOD_MAX = hrf_pkg::METHOD_MAX_DEF,
    parameter int unsigned PATH_MAX   = hrf_pkg::PATH_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hrf_pkg::t_line_ctl  i_ctl,
    input  logic [7:0]          i_byte,
    output hrf_pkg::t_line_stat o_stat
);
    import hrf_pkg::*;

    localparam int unsigned MW = $clog2(METHOD_MAX + 1);
    localparam int unsigned PW = $clog2(PATH_MAX + 1);
    localparam logic [MW-1:0] M_LIM = MW'(METHOD_MAX);
    localparam logic [PW-1:0] P_LIM = PW'(PATH_MAX);

    t_line_phase   r_phase, n_phase, e_phase;
    logic [MW-1:0] r_mlen, n_mlen, e_mlen;
    logic [PW-1:0] r_plen, n_plen, e_plen;
    logic          r_bad, n_bad, e_bad;

    always_comb begin
        e_phase = i_ctl.clear ? LP_METHOD : r_phase;
        e_mlen  = i_ctl.clear ? '0 : r_mlen;
        e_plen  = i_ctl.clear ? '0 : r_plen;
        e_bad   = i_ctl.clear ? 1'b0 : r_bad;
    end

    // next state
    always_comb begin
        n_phase = e_phase;
        n_mlen  = e_mlen;
        n_plen  = e_plen;
        n_bad   = e_bad;
        if (i_ctl.step) begin
            unique case (e_phase)
                LP_METHOD: begin
                    if (i_byte == CH_SP) begin
                        n_phase = LP_PATH;
                    end else if (i_byte == CH_NUL || e_mlen >= M_LIM) begin
                        n_bad   = 1'b1;
                        n_phase = LP_REST;
                    end else begin
                        n_mlen = e_mlen + 1'b1;
                    end
                end
                LP_PATH: begin
                    if (e_plen >= P_LIM) begin
                        n_phase = LP_REST;
                    end else if (i_byte == CH_SP || i_byte == CH_NUL) begin
                        n_phase = LP_REST;
                    end else begin
                        n_plen = e_plen + 1'b1;
                    end
                end
                default: begin
                    n_phase = e_phase;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        unique case (e_phase)
            LP_METHOD: o_stat.part = PT_METHOD;
            LP_PATH:   o_stat.part = (e_plen >= P_LIM) ? PT_REST : PT_PATH;
            default:   o_stat.part = PT_REST;
        endcase
        o_stat.bad       = n_bad;
        o_stat.in_method = (n_phase == LP_METHOD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= LP_METHOD;
            r_mlen  <= '0;
            r_plen  <= '0;
            r_bad   <= 1'b0;
        end else if (i_ctl.clear || i_ctl.step) begin
            r_phase <= n_phase;
            r_mlen  <= n_mlen;
            r_plen  <= n_plen;
            r_bad   <= n_bad;
        end
    end

endmodule

FILE: design/hrf_value.sv
// ----------------------------------------------------------------------------
// hrf_value
// Content-Length header search and atoi-style value parse, saturating.
// ----------------------------------------------------------------------------
module hrf_value (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrf_pkg::t_val_ctl  i_ctl,
    input  logic [7:0]         i_byte,
    output hrf_pkg::t_val_stat o_stat
);
    import hrf_pkg::*;

    t_val_phase       r_phase, n_phase, e_phase;
    logic [3:0]       r_pos, n_pos, e_pos;
    logic             r_lower, n_lower, e_lower;
    logic             r_neg, n_neg, e_neg;
    logic [LEN_W-1:0] r_acc, n_acc, e_acc;
    logic [LEN_W+3:0] mul;
    logic [3:0]       digit;

    always_comb begin
        e_phase = i_ctl.clear ? VP_NAME : r_phase;
        e_pos   = i_ctl.clear ? '0 : r_pos;
        e_lower = i_ctl.clear ? 1'b0 : r_lower;
        e_neg   = i_ctl.clear ? 1'b0 : r_neg;
        e_acc   = i_ctl.clear ? '0 : r_acc;
        digit   = 4'(i_byte - CH_ZERO);
        mul     = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0} + {16'd0, digit};
    end

    // next state
    always_comb begin
        n_phase = e_phase;
        n_pos   = e_pos;
        n_lower = e_lower;
        n_neg   = e_neg;
        n_acc   = e_acc;
        if (i_ctl.step) begin
            unique case (e_phase)
                VP_NAME: begin
                    if (e_pos != 4'd0 && e_pos < 4'(NAME_LEN)
                        && i_byte == hrf_name_char(e_pos, e_lower)) begin
                        n_pos = e_pos + 1'b1;
                    end else if (i_byte == CH_UC_C) begin
                        n_pos   = 4'd1;
                        n_lower = 1'b0;
                    end else if (i_byte == CH_LC_C) begin
                        n_pos   = 4'd1;
                        n_lower = 1'b1;
                    end else begin
                        n_pos = 4'd0;
                    end
                    if (n_pos >= 4'(NAME_LEN)) begin
                        n_phase = VP_COLON;
                    end
                end
                VP_COLON: begin
                    if (i_byte == CH_COLON) begin
                        n_phase = VP_SIGN;
                    end
                end
                VP_SIGN: begin
                    if (hrf_is_space(i_byte)) begin
                        n_phase = VP_SIGN;
                    end else if (i_byte == CH_MINUS || i_byte == CH_PLUS) begin
                        n_neg   = (i_byte == CH_MINUS);
                        n_phase = VP_DIGITS;
                    end else if (hrf_is_digit(i_byte)) begin
                        n_acc   = {12'd0, digit};
                        n_phase = VP_DIGITS;
                    end else begin
                        n_phase = VP_DONE;
                    end
                end
                VP_DIGITS: begin
                    if (hrf_is_digit(i_byte)) begin
                        n_acc = (mul > {4'd0, LEN_SAT}) ? LEN_SAT : mul[LEN_W-1:0];
                    end else begin
                        n_phase = VP_DONE;
                    end
                end
                default: begin
                    n_phase = e_phase;
                end
            endcase
            if (i_ctl.hdr_end) begin
                if (n_phase == VP_SIGN) begin
                    n_neg = 1'b0;
                end
                n_phase = VP_DONE;
            end
        end
    end

    // outputs
    always_comb begin
        o_stat.acc = n_acc;
        o_stat.neg = n_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= VP_NAME;
            r_pos   <= '0;
            r_lower <= 1'b0;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (i_ctl.clear || i_ctl.step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_lower <= n_lower;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

endmodule

FILE: design/http_request_framer_unit.sv
// ----------------------------------------------------------------------------
// http_request_framer_unit
// Frames one HTTP request per connection, one byte per word.
//
//  channel   direction  signals                          payload
//  in        input      i_in_valid / o_in_stall          i_in_word  (t_in_word)
//  out       output     o_out_valid / i_out_stall        o_out_word (t_out_word)
//  cfg       input      i_cfg_wr_en                      i_cfg_wr_data (limit)
//
// One word per cycle sustained while the output is not stalled; each word
// passes the input register, then the result register. The parse state
// updates in the same cycle that a word moves from the input register to the
// result register. A stalled result holds the input register; the input side
// stalls only when both registers are full. Synchronous active-low reset
// clears all parse state and sets the limit to 4096.
// ----------------------------------------------------------------------------
module http_request_framer_unit #(
    parameter int unsigned BUFFER_BYTES = hrf_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned METHOD_MAX   = hrf_pkg::METHOD_MAX_DEF,
    parameter int unsigned PATH_MAX     = hrf_pkg::PATH_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  hrf_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output hrf_pkg::t_out_word         o_out_word,
    input  logic                       i_cfg_wr_en,
    input  logic [hrf_pkg::CNT_W-1:0]  i_cfg_wr_data
);
    import hrf_pkg::*;

    localparam int unsigned CAP = (BUFFER_BYTES < 8191) ? BUFFER_BYTES : 8191;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

    logic             r_in_valid;
    t_in_word         r_in_word;
    logic             r_out_valid;
    t_out_word        r_out_word;
    logic [CNT_W-1:0] r_max;

    logic [CNT_W-1:0] r_used, n_used, e_used;
    logic [1:0]       r_term, n_term, e_term;
    logic             r_hh, n_hh, e_hh;
    logic [CNT_W-1:0] r_body, n_body, e_body;
    t_fin             r_fin, n_fin, e_fin;

    logic             advance;
    logic             clr;
    logic             counted;
    logic             hdr_end;
    logic             done;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] used_n;
    logic [LEN_W:0]   sum_end;
    logic [7:0]       b;
    t_status          status;
    t_part            part;
    t_out_word        n_out_word;

    t_line_ctl  line_ctl;
    t_line_stat line_stat;
    t_val_ctl   val_ctl;
    t_val_stat  val_stat;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign b          = r_in_word.data_byte;
    assign clr        = advance && r_in_word.conn_start;
    assign limit      = (r_max < CAP_V) ? r_max : CAP_V;

    always_comb begin
        e_used = clr ? '0 : r_used;
        e_term = clr ? '0 : r_term;
        e_hh   = clr ? 1'b0 : r_hh;
        e_body = clr ? '0 : r_body;
        e_fin  = clr ? FIN_OPEN : r_fin;
    end

    assign counted = (e_fin == FIN_OPEN) && (e_used < limit);
    assign used_n  = e_used + 1'b1;
    assign hdr_end = counted && !e_hh && (b == CH_LF) && (e_term == 2'd3);

    assign line_ctl = '{clear: clr, step: advance && counted};
    assign val_ctl  = '{clear: clr, step: advance && counted && !e_hh, hdr_end: hdr_end};

    hrf_line #(
        .METHOD_MAX (METHOD_MAX),
        .PATH_MAX   (PATH_MAX)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (line_ctl),
        .i_byte  (b),
        .o_stat  (line_stat)
    );

    hrf_value u_value (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (val_ctl),
        .i_byte  (b),
        .o_stat  (val_stat)
    );

    always_comb begin
        n_term = e_term;
        if (counted && !e_hh) begin
            if (b == CH_CR) begin
                n_term = (e_term == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == CH_LF && (e_term == 2'd1 || e_term == 2'd3)) begin
                n_term = (e_term == 2'd3) ? 2'd0 : 2'd2;
            end else begin
                n_term = 2'd0;
            end
        end
        n_hh    = e_hh || hdr_end;
        n_body  = hdr_end ? used_n : e_body;
        n_used  = counted ? used_n : e_used;
        sum_end = {4'd0, n_body} + {1'b0, val_stat.acc};
        done    = counted && n_hh && ((val_stat.acc == '0)
                  || (!val_stat.neg && {4'd0, used_n} >= sum_end));

        if (!counted) begin
            part = PT_BEYOND;
        end else if (e_hh) begin
            part = ((val_stat.neg && val_stat.acc != '0)
                    || {4'd0, used_n} <= sum_end) ? PT_BODY : PT_BEYOND;
        end else begin
            part = line_stat.part;
        end

        if (e_fin != FIN_OPEN) begin
            status = ST_IGNORE;
            n_fin  = e_fin;
        end else if (!counted) begin
            status = ST_BIG;
            n_fin  = FIN_BIG;
        end else if (done) begin
            status = (line_stat.bad || line_stat.in_method) ? ST_BAD : ST_OK;
            n_fin  = FIN_DONE;
        end else begin
            status = ST_COLLECT;
            n_fin  = FIN_OPEN;
        end

        n_out_word.status       = status;
        n_out_word.part         = part;
        n_out_word.length_value = val_stat.acc;
        n_out_word.body_start   = n_body;
        n_out_word.byte_count   = n_used;
        n_out_word.headers_seen = n_hh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max       <= CFG_MAX_RESET;
            r_used      <= '0;
            r_term      <= '0;
            r_hh        <= 1'b0;
            r_body      <= '0;
            r_fin       <= FIN_OPEN;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_used      <= n_used;
                r_term      <= n_term;
                r_hh        <= n_hh;
                r_body      <= n_body;
                r_fin       <= n_fin;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
